@@ design/a64e_pkg.sv @@
// Package with types, operation codes and opcode constants of the A64 instruction word encoder.
package a64e_pkg;

  localparam logic [5:0] OP_MOV          = 6'd0;
  localparam logic [5:0] OP_MOVIMM       = 6'd1;
  localparam logic [5:0] OP_MOVIMM_RELOC = 6'd2;
  localparam logic [5:0] OP_ADD          = 6'd3;
  localparam logic [5:0] OP_SUB          = 6'd4;
  localparam logic [5:0] OP_LSL_IMM      = 6'd5;
  localparam logic [5:0] OP_LSR_IMM      = 6'd6;
  localparam logic [5:0] OP_ASR_IMM      = 6'd7;
  localparam logic [5:0] OP_REV32        = 6'd8;
  localparam logic [5:0] OP_REV64        = 6'd9;
  localparam logic [5:0] OP_SXTW         = 6'd10;
  localparam logic [5:0] OP_LSLV         = 6'd11;
  localparam logic [5:0] OP_LSRV         = 6'd12;
  localparam logic [5:0] OP_MUL          = 6'd13;
  localparam logic [5:0] OP_UMULH        = 6'd14;
  localparam logic [5:0] OP_EXTR         = 6'd15;
  localparam logic [5:0] OP_AND          = 6'd16;
  localparam logic [5:0] OP_ORR          = 6'd17;
  localparam logic [5:0] OP_ORR_LSL      = 6'd18;
  localparam logic [5:0] OP_EOR          = 6'd19;
  localparam logic [5:0] OP_EOR_LSR      = 6'd20;
  localparam logic [5:0] OP_CMP          = 6'd21;
  localparam logic [5:0] OP_CSEL_EQ      = 6'd22;
  localparam logic [5:0] OP_LDR64        = 6'd23;
  localparam logic [5:0] OP_LDR32        = 6'd24;
  localparam logic [5:0] OP_STR64        = 6'd25;
  localparam logic [5:0] OP_BLR          = 6'd26;
  localparam logic [5:0] OP_PUSH_FP      = 6'd27;
  localparam logic [5:0] OP_POP_FP       = 6'd28;
  localparam logic [5:0] OP_PUSH_X19     = 6'd29;
  localparam logic [5:0] OP_POP_X19      = 6'd30;
  localparam logic [5:0] OP_DMB          = 6'd31;
  localparam logic [5:0] OP_ISB          = 6'd32;
  localparam logic [5:0] OP_RET          = 6'd33;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_REG    = 2'd1;
  localparam logic [1:0] ERR_SHIFT  = 2'd2;
  localparam logic [1:0] ERR_OFFSET = 2'd3;

  localparam logic [4:0]  REG_ZR        = 5'd31;
  localparam logic [15:0] OFF_MAX_64    = 16'd32760;
  localparam logic [15:0] OFF_MAX_32    = 16'd16380;
  localparam logic [15:0] HALF_ONES     = 16'hFFFF;

  localparam logic [31:0] W_MOVREG  = 32'hAA0003E0;
  localparam logic [31:0] W_ADD     = 32'h8B000000;
  localparam logic [31:0] W_SUB     = 32'hCB000000;
  localparam logic [31:0] W_LSL     = 32'hD3400000;
  localparam logic [31:0] W_LSR     = 32'hD340FC00;
  localparam logic [31:0] W_ASR     = 32'h9340FC00;
  localparam logic [31:0] W_MOVN    = 32'h92800000;
  localparam logic [31:0] W_MOVZ    = 32'hD2800000;
  localparam logic [31:0] W_MOVK    = 32'hF2800000;
  localparam logic [31:0] W_REV32   = 32'h5AC00800;
  localparam logic [31:0] W_REV64   = 32'hDAC00C00;
  localparam logic [31:0] W_SXTW    = 32'h93407C00;
  localparam logic [31:0] W_LSLV    = 32'h9AC02000;
  localparam logic [31:0] W_LSRV    = 32'h9AC02400;
  localparam logic [31:0] W_MUL     = 32'h9B007C00;
  localparam logic [31:0] W_UMULH   = 32'h9BC07C00;
  localparam logic [31:0] W_EXTR    = 32'h93C00000;
  localparam logic [31:0] W_AND     = 32'h8A000000;
  localparam logic [31:0] W_ORR     = 32'hAA000000;
  localparam logic [31:0] W_EOR     = 32'hCA000000;
  localparam logic [31:0] W_EOR_LSR = 32'hCA400000;
  localparam logic [31:0] W_CMP     = 32'hEB00001F;
  localparam logic [31:0] W_CSEL    = 32'h9A800000;
  localparam logic [31:0] W_LDR64   = 32'hF9400000;
  localparam logic [31:0] W_LDR32   = 32'hB9400000;
  localparam logic [31:0] W_STR64   = 32'hF9000000;
  localparam logic [31:0] W_BLR     = 32'hD63F0000;
  localparam logic [31:0] W_PUSH_FP = 32'hA9BF7BFD;
  localparam logic [31:0] W_POP_FP  = 32'hA8C17BFD;
  localparam logic [31:0] W_PUSH_19 = 32'hA9BF53F3;
  localparam logic [31:0] W_POP_19  = 32'hA8C153F3;
  localparam logic [31:0] W_DMB     = 32'hD5033BBF;
  localparam logic [31:0] W_ISB     = 32'hD5033FDF;
  localparam logic [31:0] W_RET     = 32'hD65F03C0;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [4:0]  reg_a;
    logic [4:0]  reg_b;
    logic [4:0]  reg_c;
    logic [7:0]  shift_amount;
    logic [15:0] byte_offset;
    logic [63:0] immediate_value;
  } req_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        last;
    logic        reloc_start;
    logic [1:0]  error_code;
  } res_t;

  typedef struct packed {
    logic       has;
    logic [3:0] pick;
    res_t       res;
  } enc_t;

endpackage

@@ design/a64e_req_if.sv @@
// Request channel interface of the A64 instruction word encoder.
interface a64e_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  req_type;
  logic [4:0]  reg_a;
  logic [4:0]  reg_b;
  logic [4:0]  reg_c;
  logic [7:0]  shift_amount;
  logic [15:0] byte_offset;
  logic [63:0] immediate_value;

  modport source (
    output valid, req_type, reg_a, reg_b, reg_c, shift_amount, byte_offset,
           immediate_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, reg_a, reg_b, reg_c, shift_amount, byte_offset,
           immediate_value,
    output ready
  );
endinterface

@@ design/a64e_res_if.sv @@
// Result channel interface of the A64 instruction word encoder.
interface a64e_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic        last;
  logic        reloc_start;
  logic [1:0]  error_code;

  modport source (
    output valid, instr_word, last, reloc_start, error_code,
    input  ready
  );
  modport sink (
    input  valid, instr_word, last, reloc_start, error_code,
    output ready
  );
endinterface

@@ design/a64_instruction_word_encoder.sv @@
// Top level of the A64 instruction word encoder: request register, encoder and result register.
//
//   channel   direction  handshake       payload
//   in_req    sink       valid / ready   req_type, reg_a, reg_b, reg_c, shift_amount,
//                                        byte_offset, immediate_value
//   out_res   source     valid / ready   instr_word, last, reloc_start, error_code
//
// A request beat is registered, encoded, and its result beats pass through the result register.
// Single-word requests sustain one beat per cycle unless the result stalls; a move-wide
// request holds the request register for one to four words, as set by the word sequencer.
// Unused operation codes are dropped without a result beat.
// Reset clears the valid flags; a stalled result beat holds while the next request waits.
module a64_instruction_word_encoder (
  input  logic            clk,
  input  logic            rst_n,
  a64e_req_if.sink        in_req,
  a64e_res_if.source      out_res
);

  a64e_pkg::req_t req_r;
  a64e_pkg::req_t req_nxt;
  logic           req_vld_r;
  logic [3:0]     done_r;
  a64e_pkg::res_t res_r;
  logic           out_vld_r;
  a64e_pkg::enc_t enc;
  logic           load_en;
  logic           step;
  logic           finish;
  logic           in_fire;

  assign req_nxt.req_type        = in_req.req_type;
  assign req_nxt.reg_a           = in_req.reg_a;
  assign req_nxt.reg_b           = in_req.reg_b;
  assign req_nxt.reg_c           = in_req.reg_c;
  assign req_nxt.shift_amount    = in_req.shift_amount;
  assign req_nxt.byte_offset     = in_req.byte_offset;
  assign req_nxt.immediate_value = in_req.immediate_value;

  a64e_encode u_encode (
    .req  (req_r),
    .done (done_r),
    .enc  (enc)
  );

  assign load_en      = !out_vld_r || out_res.ready;
  assign step         = req_vld_r && (!enc.has || load_en);
  assign finish       = step && (!enc.has || enc.res.last);
  assign in_req.ready = !req_vld_r || finish;
  assign in_fire      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      done_r    <= 4'd0;
    end else if (in_fire) begin
      req_vld_r <= 1'b1;
      done_r    <= 4'd0;
    end else if (finish) begin
      req_vld_r <= 1'b0;
    end else if (step) begin
      done_r <= done_r | enc.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_en) begin
      out_vld_r <= req_vld_r && enc.has;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && req_vld_r && enc.has) begin
      res_r <= enc.res;
    end
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.instr_word  = res_r.instr_word;
  assign out_res.last        = res_r.last;
  assign out_res.reloc_start = res_r.reloc_start;
  assign out_res.error_code  = res_r.error_code;

`ifndef SYNTH
  a_new_req_clears_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (done_r == 4'd0) && req_vld_r)
    else $error("Word sequence not restarted on a new request.");

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r |-> ($onehot(enc.pick) == enc.has))
    else $error("Word sequencer picked other than one halfword.");

  a_error_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.error_code != a64e_pkg::ERR_NONE)) |->
      (res_r.last && !res_r.reloc_start && (res_r.instr_word == 32'd0)))
    else $error("Error beat carries a word or is not last.");

  a_reloc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.reloc_start) |-> !res_r.last)
    else $error("Relocation start beat marked last.");
`endif

endmodule

@@ design/a64e_encode.sv @@
// Combinational encoder that forms the next result word of a held request.
module a64e_encode (
  input  a64e_pkg::req_t req,
  input  logic [3:0]     done,
  output a64e_pkg::enc_t enc
);

  logic [5:0]  op;
  logic [4:0]  ra;
  logic [4:0]  rb;
  logic [4:0]  rc;
  logic [5:0]  sh6;
  logic [15:0] off;
  logic        op_ok;
  logic        ua;
  logic        ub;
  logic        uc;
  logic        err_reg;
  logic        chk_shift;
  logic        err_shift;
  logic        err_off;
  logic [1:0]  err;
  logic [11:0] off_scale;
  logic [31:0] single_word;
  logic [15:0] half [4];
  logic [3:0]  nz_vec;
  logic [3:0]  no_vec;
  logic        use_movn;
  logic [3:0]  wide_mask;
  logic [3:0]  mask;
  logic [3:0]  pend;
  logic [3:0]  pick;
  logic [1:0]  idx;
  logic        first;
  logic        is_wide;
  logic        is_reloc;
  logic        movn_now;
  logic [15:0] wide_imm;
  logic [31:0] wide_base;
  logic [31:0] wide_word;
  logic [31:0] rd_w;
  logic [31:0] rn_w;
  logic [31:0] rm_w;

  assign op    = req.req_type;
  assign ra    = req.reg_a;
  assign rb    = req.reg_b;
  assign rc    = req.reg_c;
  assign sh6   = req.shift_amount[5:0];
  assign off   = req.byte_offset;
  assign op_ok = (op <= a64e_pkg::OP_RET);
  assign rd_w  = {27'd0, ra};
  assign rn_w  = {27'd0, rb} << 5;
  assign rm_w  = {27'd0, rc} << 16;

  always_comb begin
    ua = (op <= a64e_pkg::OP_BLR) || (op == a64e_pkg::OP_CMP);
    ub = (op == a64e_pkg::OP_MOV) ||
         ((op >= a64e_pkg::OP_ADD) && (op <= a64e_pkg::OP_STR64));
    uc = (op == a64e_pkg::OP_ADD) || (op == a64e_pkg::OP_SUB) ||
         ((op >= a64e_pkg::OP_LSLV) && (op <= a64e_pkg::OP_EOR_LSR)) ||
         (op == a64e_pkg::OP_CSEL_EQ);
    err_reg = (ua && (ra == a64e_pkg::REG_ZR)) || (ub && (rb == a64e_pkg::REG_ZR)) ||
              (uc && (rc == a64e_pkg::REG_ZR));
    chk_shift = ((op >= a64e_pkg::OP_LSL_IMM) && (op <= a64e_pkg::OP_ASR_IMM)) ||
                (op == a64e_pkg::OP_EXTR) || (op == a64e_pkg::OP_ORR_LSL) ||
                (op == a64e_pkg::OP_EOR_LSR);
    err_shift = chk_shift && (req.shift_amount[7:6] != 2'd0);
    err_off = 1'b0;
    off_scale = off[14:3];
    if ((op == a64e_pkg::OP_LDR64) || (op == a64e_pkg::OP_STR64)) begin
      err_off = (off[2:0] != 3'd0) || (off > a64e_pkg::OFF_MAX_64);
    end else if (op == a64e_pkg::OP_LDR32) begin
      err_off = (off[1:0] != 2'd0) || (off > a64e_pkg::OFF_MAX_32);
      off_scale = off[13:2];
    end
    if (err_reg) begin
      err = a64e_pkg::ERR_REG;
    end else if (err_shift) begin
      err = a64e_pkg::ERR_SHIFT;
    end else if (err_off) begin
      err = a64e_pkg::ERR_OFFSET;
    end else begin
      err = a64e_pkg::ERR_NONE;
    end
  end

  always_comb begin
    case (op)
      a64e_pkg::OP_MOV: single_word = a64e_pkg::W_MOVREG | ({27'd0, rb} << 16) | rd_w;
      a64e_pkg::OP_ADD: single_word = a64e_pkg::W_ADD | rm_w | rn_w | rd_w;
      a64e_pkg::OP_SUB: single_word = a64e_pkg::W_SUB | rm_w | rn_w | rd_w;
      a64e_pkg::OP_LSL_IMM: begin
        if (sh6 == 6'd0) begin
          single_word = a64e_pkg::W_MOVREG | ({27'd0, rb} << 16) | rd_w;
        end else begin
          single_word = a64e_pkg::W_LSL | ({26'd0, 6'd0 - sh6} << 16) |
                        ({26'd0, ~sh6} << 10) | rn_w | rd_w;
        end
      end
      a64e_pkg::OP_LSR_IMM: begin
        if (sh6 == 6'd0) begin
          single_word = a64e_pkg::W_MOVREG | ({27'd0, rb} << 16) | rd_w;
        end else begin
          single_word = a64e_pkg::W_LSR | ({26'd0, sh6} << 16) | rn_w | rd_w;
        end
      end
      a64e_pkg::OP_ASR_IMM: begin
        if (sh6 == 6'd0) begin
          single_word = a64e_pkg::W_MOVREG | ({27'd0, rb} << 16) | rd_w;
        end else begin
          single_word = a64e_pkg::W_ASR | ({26'd0, sh6} << 16) | rn_w | rd_w;
        end
      end
      a64e_pkg::OP_REV32: single_word = a64e_pkg::W_REV32 | rn_w | rd_w;
      a64e_pkg::OP_REV64: single_word = a64e_pkg::W_REV64 | rn_w | rd_w;
      a64e_pkg::OP_SXTW: single_word = a64e_pkg::W_SXTW | rn_w | rd_w;
      a64e_pkg::OP_LSLV: single_word = a64e_pkg::W_LSLV | rm_w | rn_w | rd_w;
      a64e_pkg::OP_LSRV: single_word = a64e_pkg::W_LSRV | rm_w | rn_w | rd_w;
      a64e_pkg::OP_MUL: single_word = a64e_pkg::W_MUL | rm_w | rn_w | rd_w;
      a64e_pkg::OP_UMULH: single_word = a64e_pkg::W_UMULH | rm_w | rn_w | rd_w;
      a64e_pkg::OP_EXTR:
        single_word = a64e_pkg::W_EXTR | rm_w | ({26'd0, sh6} << 10) | rn_w | rd_w;
      a64e_pkg::OP_AND: single_word = a64e_pkg::W_AND | rm_w | rn_w | rd_w;
      a64e_pkg::OP_ORR: single_word = a64e_pkg::W_ORR | rm_w | rn_w | rd_w;
      a64e_pkg::OP_ORR_LSL:
        single_word = a64e_pkg::W_ORR | rm_w | ({26'd0, sh6} << 10) | rn_w | rd_w;
      a64e_pkg::OP_EOR: single_word = a64e_pkg::W_EOR | rm_w | rn_w | rd_w;
      a64e_pkg::OP_EOR_LSR:
        single_word = a64e_pkg::W_EOR_LSR | rm_w | ({26'd0, sh6} << 10) | rn_w | rd_w;
      a64e_pkg::OP_CMP:
        single_word = a64e_pkg::W_CMP | ({27'd0, rb} << 16) | ({27'd0, ra} << 5);
      a64e_pkg::OP_CSEL_EQ: single_word = a64e_pkg::W_CSEL | rm_w | rn_w | rd_w;
      a64e_pkg::OP_LDR64:
        single_word = a64e_pkg::W_LDR64 | ({20'd0, off_scale} << 10) | rn_w | rd_w;
      a64e_pkg::OP_LDR32:
        single_word = a64e_pkg::W_LDR32 | ({20'd0, off_scale} << 10) | rn_w | rd_w;
      a64e_pkg::OP_STR64:
        single_word = a64e_pkg::W_STR64 | ({20'd0, off_scale} << 10) | rn_w | rd_w;
      a64e_pkg::OP_BLR: single_word = a64e_pkg::W_BLR | ({27'd0, ra} << 5);
      a64e_pkg::OP_PUSH_FP: single_word = a64e_pkg::W_PUSH_FP;
      a64e_pkg::OP_POP_FP: single_word = a64e_pkg::W_POP_FP;
      a64e_pkg::OP_PUSH_X19: single_word = a64e_pkg::W_PUSH_19;
      a64e_pkg::OP_POP_X19: single_word = a64e_pkg::W_POP_19;
      a64e_pkg::OP_DMB: single_word = a64e_pkg::W_DMB;
      a64e_pkg::OP_ISB: single_word = a64e_pkg::W_ISB;
      default: single_word = a64e_pkg::W_RET;
    endcase
  end

  // MOVIMM requests emit one word for each halfword that differs from the fill value, or one word if none differs.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      half[i]   = req.immediate_value[16*i +: 16];
      nz_vec[i] = (half[i] != 16'd0);
      no_vec[i] = (half[i] != a64e_pkg::HALF_ONES);
    end
    use_movn  = ($countones(no_vec) < $countones(nz_vec));
    wide_mask = use_movn ? no_vec : nz_vec;
    if (wide_mask == 4'd0) begin
      wide_mask = 4'b0001;
    end
  end

  always_comb begin
    is_wide  = (op == a64e_pkg::OP_MOVIMM) && (err == a64e_pkg::ERR_NONE);
    is_reloc = (op == a64e_pkg::OP_MOVIMM_RELOC) && (err == a64e_pkg::ERR_NONE);
    if (!op_ok) begin
      mask = 4'b0000;
    end else if (is_reloc) begin
      mask = 4'b1111;
    end else if (is_wide) begin
      mask = wide_mask;
    end else begin
      mask = 4'b0001;
    end
    pend  = mask & ~done;
    pick  = pend & (4'd0 - pend);
    idx   = {pick[3] | pick[2], pick[3] | pick[1]};
    first = (done == 4'd0);
    movn_now  = is_wide && use_movn && first;
    wide_imm  = movn_now ? ~half[idx] : half[idx];
    if (!first) begin
      wide_base = a64e_pkg::W_MOVK;
    end else if (movn_now) begin
      wide_base = a64e_pkg::W_MOVN;
    end else begin
      wide_base = a64e_pkg::W_MOVZ;
    end
    wide_word = wide_base | ({30'd0, idx} << 21) | ({16'd0, wide_imm} << 5) | rd_w;

    enc.has  = (pend != 4'd0);
    enc.pick = pick;
    enc.res.last        = ((pend & ~pick) == 4'd0);
    enc.res.reloc_start = is_reloc && first;
    enc.res.error_code  = err;
    if (err != a64e_pkg::ERR_NONE) begin
      enc.res.instr_word = 32'd0;
    end else if (is_wide || is_reloc) begin
      enc.res.instr_word = wide_word;
    end else begin
      enc.res.instr_word = single_word;
    end
  end

endmodule
